/* sv/ordered_key_value_list_assert.svh */
// ----------------------------------------------------------------------------
// ordered_key_value_list_assert.svh
// Assertion macros shared by the checker of the ordered key/value table
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_VALUE_LIST_ASSERT_SVH
`define ORDERED_KEY_VALUE_LIST_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OKVL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define OKVL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/okvl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvl_pkg
// Types, constants and the key canonicalization function of the
// ordered key/value table
// ----------------------------------------------------------------------------
package okvl_pkg;

  // table size and derived widths
  localparam int DEPTH     = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W     = 11;
  localparam int NUM_W     = 32;
  localparam int KEY_HI_W  = 16;
  localparam int KEY_LO_W  = 64;
  localparam int KEY_W     = KEY_HI_W + KEY_LO_W;
  localparam int KEY_BYTES = KEY_W / 8;

  // operation codes
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_APPEND    = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_DEL_KEY   = 3'd4,
    OP_FIND_POS  = 3'd5,
    OP_FIND_NUM  = 3'd6
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FINISH
  } state_t;

  // walk pointer start points
  typedef enum logic [1:0] {
    PTR_ZERO,
    PTR_ONE,
    PTR_COUNT
  } ptr_sel_t;

  // input beat
  typedef struct packed {
    logic [2:0]              op;
    logic [KEY_HI_W-1:0]     key_high;
    logic [KEY_LO_W-1:0]     key_low;
    logic signed [NUM_W-1:0] number_in;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [1:0]              status;
    logic [POS_W-1:0]        position;
    logic signed [NUM_W-1:0] number_out;
  } out_item_t;

  // canonical key
  typedef struct packed {
    logic [KEY_HI_W-1:0] hi;
    logic [KEY_LO_W-1:0] lo;
  } key_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [KEY_HI_W-1:0] key_high;
    logic [KEY_LO_W-1:0] key_low;
    logic [NUM_W-1:0]    value;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     ptr_ld;
    ptr_sel_t ptr_sel;
    logic     search;
    logic     shift_up;
    logic     shift_dn;
    logic     wr_new;
    logic     wr_back;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     out_load;
    status_t  out_status;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       hit;
    logic       more_up;
    logic       more_dn;
    logic       pend;
  } dp_stat_t;

  // clear every byte after the first zero byte of the name
  function automatic key_t canon_key(input logic [KEY_HI_W-1:0] hi,
                                     input logic [KEY_LO_W-1:0] lo);
    logic [KEY_W-1:0] v;
    logic             ended;
    key_t             k;
    v     = {hi, lo};
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (ended) begin
        v[KEY_W-1-8*i -: 8] = 8'h00;
      end else if (v[KEY_W-1-8*i -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    k.hi = v[KEY_W-1 -: KEY_HI_W];
    k.lo = v[KEY_LO_W-1:0];
    return k;
  endfunction

endpackage

/* sv/okvl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvl_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module okvl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/okvl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvl_ctrl
// Controller of the ordered key/value table: decodes the operation and
// sequences search, shift and result steps of the datapath
// ----------------------------------------------------------------------------
module okvl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  okvl_pkg::dp_stat_t stat,
  output okvl_pkg::dp_cmd_t  cmd
);
  import okvl_pkg::*;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    out_valid_r, out_valid_nxt;

  // state, status code and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    cmd            = '0;
    cmd.ptr_sel    = PTR_ZERO;
    cmd.out_status = st_r;
    in_ready       = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        case (stat.op)
          OP_INS_FRONT: begin
            if (stat.full) begin
              st_nxt    = ST_FULL;
              state_nxt = S_FINISH;
            end else begin
              cmd.ptr_ld  = 1'b1;
              cmd.ptr_sel = PTR_COUNT;
              state_nxt   = S_SHIFT_UP;
            end
          end
          OP_APPEND: begin
            if (stat.full) begin
              st_nxt = ST_FULL;
            end else begin
              cmd.wr_new  = 1'b1;
              cmd.wr_back = 1'b1;
              cmd.cnt_inc = 1'b1;
              st_nxt      = ST_OK;
            end
            state_nxt = S_FINISH;
          end
          OP_DEL_FRONT: begin
            if (stat.empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_FINISH;
            end else begin
              cmd.ptr_ld  = 1'b1;
              cmd.ptr_sel = PTR_ONE;
              state_nxt   = S_SHIFT_DN;
            end
          end
          OP_DEL_BACK: begin
            if (stat.empty) begin
              st_nxt = ST_EMPTY;
            end else begin
              cmd.cnt_dec = 1'b1;
              st_nxt      = ST_OK;
            end
            state_nxt = S_FINISH;
          end
          OP_DEL_KEY, OP_FIND_POS, OP_FIND_NUM: begin
            if (stat.empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_FINISH;
            end else begin
              cmd.ptr_ld  = 1'b1;
              cmd.ptr_sel = PTR_ZERO;
              state_nxt   = S_SEARCH;
            end
          end
          default: begin
            st_nxt    = ST_OK;
            state_nxt = S_FINISH;
          end
        endcase
      end

      // walk the table until the first match or the end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.hit) begin
          st_nxt    = ST_OK;
          state_nxt = (stat.op == OP_DEL_KEY) ? S_SHIFT_DN : S_FINISH;
        end else if (!stat.more_dn && !stat.pend) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_FINISH;
        end
      end

      // move entries one slot back, then write the new front entry
      S_SHIFT_UP: begin
        cmd.shift_up = 1'b1;
        if (!stat.more_up && !stat.pend) begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          st_nxt      = ST_OK;
          state_nxt   = S_FINISH;
        end
      end

      // move entries one slot forward over the removed one
      S_SHIFT_DN: begin
        cmd.shift_dn = 1'b1;
        if (!stat.more_dn && !stat.pend) begin
          cmd.cnt_dec = 1'b1;
          st_nxt      = ST_OK;
          state_nxt   = S_FINISH;
        end
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/okvl_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvl_datapath
// Datapath of the ordered key/value table: entry memory, walk pointer,
// key compare, entry count and result register
// ----------------------------------------------------------------------------
module okvl_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  okvl_pkg::in_item_t  in_data,
  input  okvl_pkg::dp_cmd_t   cmd,
  output okvl_pkg::dp_stat_t  stat,
  output okvl_pkg::out_item_t out_data
);
  import okvl_pkg::*;

  // captured operation
  logic [2:0]          op_r;
  logic [KEY_HI_W-1:0] key_hi_r;
  logic [KEY_LO_W-1:0] key_lo_r;
  logic [NUM_W-1:0]    num_r;
  key_t                key_c;

  // table and walk state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt, ptr_dec;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0] hit_idx_r;
  logic [NUM_W-1:0] hit_val_r;
  out_item_t        out_data_r;

  // memory ports
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rd_entry;
  logic             match, more_up, more_dn;

  okvl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  assign key_c = canon_key(in_data.key_high, in_data.key_low);

  // capture the beat with its key canonicalized
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_data.op;
      key_hi_r <= key_c.hi;
      key_lo_r <= key_c.lo;
      num_r    <= in_data.number_in;
    end
  end

  // compare and walk conditions
  assign match   = pend_r && (rd_entry.key_high == key_hi_r) &&
                   (rd_entry.key_low == key_lo_r);
  assign more_up = (ptr_r != '0);
  assign more_dn = (ptr_r < count_r);
  assign ptr_dec = ptr_r - CNT_W'(1);

  // read issue
  assign re    = (cmd.search && !match && more_dn) || (cmd.shift_dn && more_dn) ||
                 (cmd.shift_up && more_up);
  assign raddr = cmd.shift_up ? ptr_dec[IDX_W-1:0] : ptr_r[IDX_W-1:0];

  // walk pointer and pending read tracking
  always_comb begin
    ptr_nxt      = ptr_r;
    pend_nxt     = re;
    pend_idx_nxt = re ? raddr : pend_idx_r;
    if (cmd.ptr_ld) begin
      case (cmd.ptr_sel)
        PTR_ZERO:  ptr_nxt = '0;
        PTR_ONE:   ptr_nxt = CNT_W'(1);
        PTR_COUNT: ptr_nxt = count_r;
        default:   ptr_nxt = '0;
      endcase
    end else if (cmd.search && match) begin
      ptr_nxt = CNT_W'(pend_idx_r) + CNT_W'(1);
    end else if (re) begin
      ptr_nxt = cmd.shift_up ? ptr_dec : ptr_r + CNT_W'(1);
    end
  end

  // write port: shifted entry or new entry
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rd_entry;
    if (cmd.shift_up && pend_r) begin
      we    = 1'b1;
      waddr = pend_idx_r + IDX_W'(1);
    end else if (cmd.shift_dn && pend_r) begin
      we    = 1'b1;
      waddr = pend_idx_r - IDX_W'(1);
    end else if (cmd.wr_new) begin
      we             = 1'b1;
      waddr          = cmd.wr_back ? count_r[IDX_W-1:0] : '0;
      wdata.key_high = key_hi_r;
      wdata.key_low  = key_lo_r;
      wdata.value    = num_r;
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    pend_idx_r <= pend_idx_nxt;
  end

  // first match record
  always_ff @(posedge clk) begin
    if (cmd.search && match) begin
      hit_idx_r <= pend_idx_r;
      hit_val_r <= rd_entry.value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.status <= cmd.out_status;
      out_data_r.position <= (cmd.out_status == ST_OK && op_r == OP_FIND_POS) ?
                             POS_W'(hit_idx_r) + POS_W'(1) : '0;
      out_data_r.number_out <= (cmd.out_status == ST_OK && op_r == OP_FIND_NUM) ?
                               hit_val_r : '0;
    end
  end

  assign out_data = out_data_r;

  // status to the controller
  assign stat.op      = op_r;
  assign stat.empty   = (count_r == '0);
  assign stat.full    = (count_r == CNT_W'(DEPTH));
  assign stat.hit     = match;
  assign stat.more_up = more_up;
  assign stat.more_dn = more_dn;
  assign stat.pend    = pend_r;

endmodule

/* sv/ordered_key_value_list.sv */
// Append, delete back, refusals and the spare opcode finish without a walk; find
// walks from the front to the first match or the end; insert front moves every
// entry one slot back, then writes the front; delete front and delete key (after
// its find) move the later entries one slot forward. Throughput: one item at a time,
// next beat taken from when result valid rises, walk paced by the single RAM read port.
// Reset (synchronous, rst_n low) empties the table; entry RAM is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_value_list
// Ordered table of name/number entries with front and back insert, delete
// by position or key, and key search
// ----------------------------------------------------------------------------
module ordered_key_value_list (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  okvl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output okvl_pkg::out_item_t out_data
);
  import okvl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  okvl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage, compare and result
  okvl_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* sv/okvl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvl_checker
// Port-level assertions for the ordered key/value table, bound to the top
// ----------------------------------------------------------------------------
`include "ordered_key_value_list_assert.svh"

module okvl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input okvl_pkg::out_item_t out_data
);
  import okvl_pkg::*;

  // a stalled result beat holds
  `OKVL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // one item at a time: no accept right after an accept
  `OKVL_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input ready right after accept")

  // position and number only on an ok result, never both
  `OKVL_ASSERT_NOW(a_ok_only, out_valid && (out_data.position != '0 || out_data.number_out != '0), out_data.status == ST_OK && (out_data.position == '0 || out_data.number_out == '0), "position or number on a failed result")

  // position never beyond the table size
  `OKVL_ASSERT_NOW(a_pos_range, out_valid, out_data.position <= POS_W'(DEPTH), "position beyond table size")

endmodule

bind ordered_key_value_list okvl_checker u_okvl_checker (.*);
